// ===== design/rled_pkg.sv =====
// Shared types and constants of the run-length RGB565 frame decoder.
// No dependencies; every design file imports this package.
package rled_pkg;

  // Default largest frame side in pixels
  localparam int MAX_SIDE_DEF = 1024;

  // Field widths fixed by the stream format
  localparam int BYTE_W   = 8;
  localparam int WORD_W   = 16;
  localparam int CFG_W    = 11;
  localparam int CFG_IDX_W = 2;
  localparam int LEN_W    = 11;
  localparam int POS_W    = 10;
  localparam int STAT_W   = 2;
  localparam int OUT_DATA_W = 56;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd2;

  // Register reset values
  localparam logic             MODE_RST   = 1'b1;
  localparam logic [CFG_W-1:0] WIDTH_RST  = 11'd64;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 11'd64;

  // Frame status codes
  localparam logic [STAT_W-1:0] ST_OK  = 2'd0;
  localparam logic [STAT_W-1:0] ST_RLE = 2'd1;
  localparam logic [STAT_W-1:0] ST_RAW = 2'd2;

  // Parse phase of run-length mode
  typedef enum logic [3:0] {
    PH_COUNT = 4'b0001,
    PH_LEN   = 4'b0010,
    PH_PIXEL = 4'b0100,
    PH_DONE  = 4'b1000
  } phase_t;

  // Configuration register set
  typedef struct packed {
    logic             rle_mode;
    logic [CFG_W-1:0] frame_width;
    logic [CFG_W-1:0] frame_height;
  } cfg_t;

  // One input request
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } in_req_t;

  // One result request
  typedef struct packed {
    logic              run_valid;
    logic [WORD_W-1:0] pixel_value;
    logic [LEN_W-1:0]  run_length;
    logic [POS_W-1:0]  run_row;
    logic [POS_W-1:0]  run_column;
    logic              frame_done;
    logic [STAT_W-1:0] frame_status;
  } result_t;

  // Handshake between the input register and the decode stage
  typedef struct packed {
    logic valid;
    logic take;
  } stage_ctl_t;

endpackage

// ===== design/rle_rgb565_frame_decoder.sv =====
// Run-length RGB565 frame decoder, top level.
// Each accepted byte is held in the input register; its result then goes to the output register.
// Throughput: one payload byte per cycle while the result register is free, set by the single
// decode stage between the input register and the result register.
// Reset (rst_n low, synchronous): registers to mode 1, 64x64 frame; parse state
// cleared; both stream registers empty. Depends on rled_pkg and the rled_* modules.
module rle_rgb565_frame_decoder #(
  parameter int MAX_SIDE = rled_pkg::MAX_SIDE_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  // Configuration write port
  input  logic                                     cfg_wen,
  input  logic [rled_pkg::CFG_IDX_W-1:0]           cfg_addr,
  input  logic [rled_pkg::CFG_W-1:0]               cfg_wdata,
  // Input stream
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  input  logic [rled_pkg::BYTE_W-1:0]              in_tdata,  // [7:0] data_byte
  input  logic                                     in_tlast,  // last_byte
  // Result stream
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  // [15:0] pixel_value, [26:16] run_length, [36:27] run_row,
  // [46:37] run_column, [48:47] frame_status, [55:49] zero
  output logic [rled_pkg::OUT_DATA_W-1:0]          out_tdata,
  output logic                                     out_tuser, // run_valid
  output logic                                     out_tlast  // frame_done
);
  import rled_pkg::*;

  cfg_t       cfg_r;
  in_req_t    in_req, req;
  stage_ctl_t ctl;
  logic       has_result;
  logic       out_free;
  result_t    result, out_res;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rle_mode     <= MODE_RST;
      cfg_r.frame_width  <= WIDTH_RST;
      cfg_r.frame_height <= HEIGHT_RST;
    end else if (cfg_wen) begin
      case (cfg_addr)
        CFG_IDX_MODE:   cfg_r.rle_mode     <= cfg_wdata[0];
        CFG_IDX_WIDTH:  cfg_r.frame_width  <= cfg_wdata;
        CFG_IDX_HEIGHT: cfg_r.frame_height <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign in_req.data_byte = in_tdata;
  assign in_req.last_byte = in_tlast;

  // Move a held byte on only when the result register can take its outcome
  assign ctl.take = ctl.valid && out_free;

  rled_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_req    (in_req),
    .take      (ctl.take),
    .req_valid (ctl.valid),
    .req       (req)
  );

  rled_parser #(
    .MAX_SIDE (MAX_SIDE)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .advance    (ctl.take),
    .req        (req),
    .has_result (has_result),
    .result     (result)
  );

  rled_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (ctl.take && has_result),
    .result     (result),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  // Pack result fields onto the stream
  assign out_tdata = {7'd0, out_res.frame_status, out_res.run_column, out_res.run_row,
                      out_res.run_length, out_res.pixel_value};
  assign out_tuser = out_res.run_valid;
  assign out_tlast = out_res.frame_done;

endmodule

// ===== design/rled_in_stage.sv =====
// Input register of the frame decoder: holds one payload byte request.
// Depends on rled_pkg.
module rled_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  rled_pkg::in_req_t in_req,
  input  logic              take,
  output logic              req_valid,
  output rled_pkg::in_req_t req
);
  import rled_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  in_req_t req_r;

  // Accept when empty or when the held request moves on this cycle
  assign in_tready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Load payload on every accepted request
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      req_r <= in_req;
    end
  end

  assign req_valid = valid_r;
  assign req       = req_r;

endmodule

// ===== design/rled_parser.sv =====
// Decode stage: pairs bytes into words, tracks rows, runs and errors.
// Depends on rled_pkg; state advances once per request taken from the input register.
module rled_parser #(
  parameter int MAX_SIDE = rled_pkg::MAX_SIDE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  rled_pkg::cfg_t    cfg,
  input  logic              advance,
  input  rled_pkg::in_req_t req,
  output logic              has_result,
  output rled_pkg::result_t result
);
  import rled_pkg::*;

  localparam int SW   = $clog2(MAX_SIDE + 1);
  localparam int CLW  = $clog2(2 * MAX_SIDE + 2);
  localparam int CW   = 2 * SW;
  localparam int CMPW = (SW > CFG_W) ? SW : CFG_W;
  localparam int SUMW = ((CLW > WORD_W) ? CLW : WORD_W) + 1;

  phase_t             phase_r, phase_nxt;
  logic [BYTE_W-1:0]  low_r, low_nxt;
  logic               half_r, half_nxt;
  logic [WORD_W-1:0]  runs_r, runs_nxt;
  logic [SW-1:0]      held_r, held_nxt;
  logic [CLW-1:0]     col_r, col_nxt;
  logic [CW-1:0]      row_r, row_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [STAT_W-1:0]  err_r, err_nxt;

  logic [SW-1:0]      w, h;
  logic [CW-1:0]      area;
  logic [WORD_W-1:0]  word;
  logic               valid;
  logic [STAT_W-1:0]  status;

  // Clamp frame sides to 1..MAX_SIDE
  always_comb begin
    if (cfg.frame_width == '0) begin
      w = SW'(1);
    end else if (CMPW'(cfg.frame_width) > CMPW'(MAX_SIDE)) begin
      w = SW'(MAX_SIDE);
    end else begin
      w = SW'(cfg.frame_width);
    end
    if (cfg.frame_height == '0) begin
      h = SW'(1);
    end else if (CMPW'(cfg.frame_height) > CMPW'(MAX_SIDE)) begin
      h = SW'(MAX_SIDE);
    end else begin
      h = SW'(cfg.frame_height);
    end
  end

  assign area = CW'(w) * CW'(h);
  assign word = {req.data_byte, low_r};

  // Next state and result of the current byte
  always_comb begin
    phase_nxt = phase_r;
    low_nxt   = low_r;
    half_nxt  = half_r;
    runs_nxt  = runs_r;
    held_nxt  = held_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    count_nxt = count_r;
    err_nxt   = err_r;
    valid     = 1'b0;
    result    = '0;
    status    = ST_OK;

    if (err_r == ST_OK) begin
      if (cfg.rle_mode && phase_r == PH_DONE) begin
        // Byte after the final row
        err_nxt = ST_RLE;
      end else if (!half_r) begin
        low_nxt  = req.data_byte;
        half_nxt = 1'b1;
      end else begin
        half_nxt = 1'b0;
        if (!cfg.rle_mode) begin
          // Raw pixel at the next raster position
          if (count_r >= area) begin
            err_nxt = ST_RAW;
          end else begin
            valid              = 1'b1;
            result.pixel_value = word;
            result.run_length  = LEN_W'(1);
            result.run_row     = POS_W'(row_r);
            result.run_column  = POS_W'(col_r);
            count_nxt          = count_r + CW'(1);
            col_nxt            = col_r + CLW'(1);
            if (col_nxt >= CLW'(w)) begin
              col_nxt = '0;
              row_nxt = row_r + CW'(1);
            end
          end
        end else begin
          case (phase_r)
            PH_COUNT: begin
              runs_nxt = word;
              col_nxt  = '0;
              if (word == '0) begin
                err_nxt = ST_RLE;
              end else begin
                phase_nxt = PH_LEN;
              end
            end
            PH_LEN: begin
              held_nxt = SW'(word);
              if (word == '0 || (SUMW'(word) + SUMW'(col_r)) > SUMW'(w)) begin
                err_nxt = ST_RLE;
              end else begin
                phase_nxt = PH_PIXEL;
              end
            end
            PH_PIXEL: begin
              valid              = 1'b1;
              result.pixel_value = word;
              result.run_length  = LEN_W'(held_r);
              result.run_row     = POS_W'(row_r);
              result.run_column  = POS_W'(col_r);
              col_nxt            = col_r + CLW'(held_r);
              runs_nxt           = runs_r - WORD_W'(1);
              if (runs_nxt != '0) begin
                phase_nxt = PH_LEN;
              end else if (col_nxt != CLW'(w)) begin
                err_nxt = ST_RLE;
              end else begin
                col_nxt   = '0;
                row_nxt   = row_r + CW'(1);
                phase_nxt = (row_nxt >= CW'(h)) ? PH_DONE : PH_COUNT;
              end
            end
            default: begin
            end
          endcase
        end
      end
    end

    // Report status on the last byte and start the next frame afresh
    if (req.last_byte) begin
      if (err_nxt != ST_OK) begin
        status = err_nxt;
      end else if (cfg.rle_mode) begin
        status = (phase_nxt == PH_DONE && !half_nxt) ? ST_OK : ST_RLE;
      end else begin
        status = (!half_nxt && count_nxt == area) ? ST_OK : ST_RAW;
      end
      phase_nxt = PH_COUNT;
      low_nxt   = '0;
      half_nxt  = 1'b0;
      runs_nxt  = '0;
      held_nxt  = '0;
      col_nxt   = '0;
      row_nxt   = '0;
      count_nxt = '0;
      err_nxt   = ST_OK;
    end

    result.run_valid    = valid;
    result.frame_done   = req.last_byte;
    result.frame_status = status;
    has_result          = valid || req.last_byte;
  end

  // Advance parse state once per taken request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_COUNT;
      low_r   <= '0;
      half_r  <= 1'b0;
      runs_r  <= '0;
      held_r  <= '0;
      col_r   <= '0;
      row_r   <= '0;
      count_r <= '0;
      err_r   <= ST_OK;
    end else if (advance) begin
      phase_r <= phase_nxt;
      low_r   <= low_nxt;
      half_r  <= half_nxt;
      runs_r  <= runs_nxt;
      held_r  <= held_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      count_r <= count_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

// ===== design/rled_out_stage.sv =====
// Result register of the frame decoder: holds one result request for the sink.
// Depends on rled_pkg.
module rled_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  rled_pkg::result_t result,
  output logic              free,
  output logic              out_tvalid,
  input  logic              out_tready,
  output rled_pkg::result_t out_res
);
  import rled_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  // Free when empty or when the held result leaves this cycle
  assign free = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture a new result
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= result;
    end
  end

  assign out_tvalid = valid_r;
  assign out_res    = res_r;

endmodule

// ===== test/rle_rgb565_frame_decoder_test.sv =====
// Self-checking testbench for rle_rgb565_frame_decoder: raw and run-length frames,
// broken streams and register sweeps, checked against a cycle-free decode model.
// Depends on rled_pkg and the decoder RTL only.
module rle_rgb565_frame_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rled_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned DRAIN_WAIT  = 4;
  localparam int unsigned RAND_BYTES  = 300;

  // Defects that a generated frame may carry
  typedef enum int {
    FL_NONE,
    FL_ZERO_COUNT,
    FL_ZERO_LEN,
    FL_OVERRUN,
    FL_SHORT_ROW,
    FL_TRUNCATE,
    FL_TRAILING
  } flaw_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr = '0;
  logic [CFG_W-1:0]      cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [BYTE_W-1:0]     in_tdata = '0;   // [7:0] data_byte
  logic                  in_tlast = 1'b0; // last_byte
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // [15:0] pixel_value, [26:16] run_length, [36:27] run_row,
  // [46:37] run_column, [48:47] frame_status, [55:49] zero
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;       // run_valid
  logic                  out_tlast;       // frame_done

  rle_rgb565_frame_decoder uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // Decode model: register copies and parse state
  logic             mode_q;
  logic [CFG_W-1:0] width_q;
  logic [CFG_W-1:0] height_q;
  phase_t           phase_q;
  logic [7:0]       low_q;
  logic             half_q;
  logic [15:0]      runs_left_q;
  logic [15:0]      len_hold_q;
  logic [10:0]      col_q;
  logic [10:0]      row_q;
  logic [20:0]      pix_count_q;
  logic [1:0]       error_q;

  in_req_t     byte_feed[$];
  result_t     runs_due[$];
  logic [7:0]  frame_bytes[$];

  bit          calm = 1'b0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  int unsigned cycles = 0;
  int unsigned fails = 0;
  int unsigned bytes_fed = 0;
  int unsigned results_seen = 0;
  int unsigned runs_checked = 0;
  int unsigned frames_checked = 0;

  function automatic int unsigned clamp_side(logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_SIDE_DEF) return MAX_SIDE_DEF;
    return 32'(v);
  endfunction

  function automatic void clear_frame();
    phase_q     = PH_COUNT;
    low_q       = '0;
    half_q      = 1'b0;
    runs_left_q = '0;
    len_hold_q  = '0;
    col_q       = '0;
    row_q       = '0;
    pix_count_q = '0;
    error_q     = ST_OK;
  endfunction

  // Advance the decode model by one byte; return 1 when it yields a result
  function automatic bit decode_byte(input logic [7:0] b, input logic lst,
                                     output result_t res);
    int unsigned w;
    int unsigned h;
    logic [15:0] wd;
    bit          rle;
    bit          vld;
    w   = clamp_side(width_q);
    h   = clamp_side(height_q);
    rle = mode_q;
    vld = 1'b0;
    res = '0;
    if (error_q == ST_OK) begin
      if (rle && phase_q == PH_DONE) begin
        error_q = ST_RLE;
      end else if (!half_q) begin
        low_q  = b;
        half_q = 1'b1;
      end else begin
        wd     = {b, low_q};
        half_q = 1'b0;
        if (!rle) begin
          if (pix_count_q >= w * h) begin
            error_q = ST_RAW;
          end else begin
            vld             = 1'b1;
            res.pixel_value = wd;
            res.run_length  = 11'd1;
            res.run_row     = row_q[POS_W-1:0];
            res.run_column  = col_q[POS_W-1:0];
            pix_count_q     = pix_count_q + 1'b1;
            col_q           = col_q + 1'b1;
            if (col_q >= w) begin
              col_q = '0;
              row_q = row_q + 1'b1;
            end
          end
        end else if (phase_q == PH_COUNT) begin
          runs_left_q = wd;
          col_q       = '0;
          if (wd == 0) error_q = ST_RLE;
          else phase_q = PH_LEN;
        end else if (phase_q == PH_LEN) begin
          len_hold_q = wd;
          if (wd == 0 || wd + col_q > w) error_q = ST_RLE;
          else phase_q = PH_PIXEL;
        end else begin
          vld             = 1'b1;
          res.pixel_value = wd;
          res.run_length  = len_hold_q[LEN_W-1:0];
          res.run_row     = row_q[POS_W-1:0];
          res.run_column  = col_q[POS_W-1:0];
          col_q           = col_q + len_hold_q[10:0];
          runs_left_q     = runs_left_q - 1'b1;
          if (runs_left_q != 0) begin
            phase_q = PH_LEN;
          end else if (col_q != w) begin
            error_q = ST_RLE;
          end else begin
            col_q   = '0;
            row_q   = row_q + 1'b1;
            phase_q = (row_q >= h) ? PH_DONE : PH_COUNT;
          end
        end
      end
    end
    // Last byte closes the frame and reports its status
    if (lst) begin
      if (error_q != ST_OK) res.frame_status = error_q;
      else if (rle) res.frame_status = (phase_q == PH_DONE && !half_q) ? ST_OK : ST_RLE;
      else res.frame_status = (!half_q && pix_count_q == w * h) ? ST_OK : ST_RAW;
      res.frame_done = 1'b1;
      clear_frame();
    end
    res.run_valid = vld;
    return vld || lst;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      if (fails < 10)
        $display("mismatch in %s of result %0d: expected %h, got %h",
                 name, results_seen, want, got);
      fails++;
    end
  endfunction

  // Input side: present the oldest pending byte, idle in random bursts
  always @(posedge clk) begin : feed_bytes
    result_t res;
    bit      show;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!(in_tvalid && !in_tready)) begin
      if (in_tvalid) begin
        if (decode_byte(byte_feed[0].data_byte, byte_feed[0].last_byte, res))
          runs_due.push_back(res);
        void'(byte_feed.pop_front());
        bytes_fed++;
      end
      if (send_gap != 0) send_gap--;
      else if (!calm && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 6);
      show = (send_gap == 0) && (byte_feed.size() != 0);
      in_tvalid <= show;
      if (show) begin
        in_tdata <= byte_feed[0].data_byte;
        in_tlast <= byte_feed[0].last_byte;
      end
    end
  end

  // Result side: compare each accepted request with the oldest expectation
  always @(posedge clk) begin : take_results
    result_t want;
    result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.run_valid    = out_tuser;
      got.pixel_value  = out_tdata[15:0];
      got.run_length   = out_tdata[26:16];
      got.run_row      = out_tdata[36:27];
      got.run_column   = out_tdata[46:37];
      got.frame_status = out_tdata[48:47];
      got.frame_done   = out_tlast;
      if (runs_due.size() == 0) begin
        if (fails < 10) $display("unexpected result %0d: %h", results_seen, got);
        fails++;
      end else begin
        want = runs_due.pop_front();
        check_field("run_valid", 16'(want.run_valid), 16'(got.run_valid));
        check_field("pixel_value", want.pixel_value, got.pixel_value);
        check_field("run_length", 16'(want.run_length), 16'(got.run_length));
        check_field("run_row", 16'(want.run_row), 16'(got.run_row));
        check_field("run_column", 16'(want.run_column), 16'(got.run_column));
        check_field("frame_done", 16'(want.frame_done), 16'(got.frame_done));
        check_field("frame_status", 16'(want.frame_status), 16'(got.frame_status));
        check_field("padding", '0, 16'(out_tdata[55:49]));
      end
      results_seen++;
      if (got.run_valid === 1'b1) runs_checked++;
      if (got.frame_done === 1'b1) frames_checked++;
    end
    if (recv_gap != 0) recv_gap--;
    else if (!calm && $urandom_range(0, 7) == 0) recv_gap = $urandom_range(1, 6);
    out_tready <= (recv_gap == 0);
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("rle_rgb565_frame_decoder_test: errors");
      $finish;
    end
  end

  // Write one register and mirror it in the model
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_IDX_MODE:   mode_q = val[0];
      CFG_IDX_WIDTH:  width_q = val;
      CFG_IDX_HEIGHT: height_q = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  task automatic set_frame(logic mode, logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    write_reg(CFG_IDX_MODE, {{(CFG_W-1){1'b0}}, mode});
    write_reg(CFG_IDX_WIDTH, w);
    write_reg(CFG_IDX_HEIGHT, h);
  endtask

  // Hold until every byte is taken and every result has arrived
  task automatic settle();
    while (byte_feed.size() != 0 || runs_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic void put_word(logic [15:0] wd);
    frame_bytes.push_back(wd[7:0]);
    frame_bytes.push_back(wd[15:8]);
  endfunction

  // Move the staged bytes to the feed, marking the final one when closing
  function automatic void send_frame(bit close);
    in_req_t req;
    foreach (frame_bytes[i]) begin
      req.data_byte = frame_bytes[i];
      req.last_byte = close && (i == frame_bytes.size() - 1);
      byte_feed.push_back(req);
    end
    frame_bytes.delete();
  endfunction

  // Apply a stream-level defect to the staged bytes
  function automatic void mangle_tail(flaw_t flaw);
    int unsigned keep;
    if (flaw == FL_TRUNCATE && frame_bytes.size() > 1) begin
      keep = $urandom_range(1, frame_bytes.size() - 1);
      while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
    end else if (flaw == FL_TRAILING) begin
      repeat ($urandom_range(1, 3)) frame_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  // Stage a run-length frame for a w x h picture
  function automatic void build_rle(int unsigned w, int unsigned h, flaw_t flaw);
    logic [15:0] lens[$];
    int unsigned left;
    int unsigned n;
    int unsigned bad_row;
    bad_row = $urandom_range(0, h - 1);
    for (int unsigned r = 0; r < h; r++) begin
      lens.delete();
      left = w;
      while (left > 0) begin
        n = (left > 1 && $urandom_range(0, 2) != 0) ? $urandom_range(1, left) : left;
        lens.push_back(16'(n));
        left -= n;
      end
      if (r == bad_row) begin
        case (flaw)
          FL_ZERO_LEN: lens[$urandom_range(0, lens.size() - 1)] = '0;
          FL_OVERRUN:  lens[lens.size() - 1] += 16'($urandom_range(1, 3));
          FL_SHORT_ROW: begin
            if (lens[lens.size() - 1] > 1) lens[lens.size() - 1]--;
            else if (lens.size() > 1) void'(lens.pop_back());
            else lens[0] = 16'd2;
          end
          default: ;
        endcase
      end
      put_word((flaw == FL_ZERO_COUNT && r == bad_row) ? 16'd0 : 16'(lens.size()));
      foreach (lens[i]) begin
        put_word(lens[i]);
        put_word(16'($urandom_range(0, 65535)));
      end
    end
    mangle_tail(flaw);
  endfunction

  // Stage a raw frame; big pictures get only a short prefix
  function automatic void build_raw(int unsigned w, int unsigned h, flaw_t flaw);
    int unsigned words;
    words = (w * h > 64) ? $urandom_range(0, 32) : w * h;
    repeat (words) put_word(16'($urandom_range(0, 65535)));
    mangle_tail(flaw);
    if (frame_bytes.size() == 0) frame_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  initial begin : stimulus
    int unsigned rand_bytes;
    int unsigned w_eff;
    int unsigned h_eff;
    logic [CFG_W-1:0] w_set;
    logic [CFG_W-1:0] h_set;
    logic        mode;
    flaw_t       flaw;
    mode_q   = MODE_RST;
    width_q  = WIDTH_RST;
    height_q = HEIGHT_RST;
    clear_frame();
    rand_bytes = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: one full 64-pixel row, then a stream cut mid-word
    put_word(16'd1);
    put_word(16'd64);
    put_word(16'hF800);
    frame_bytes.push_back(8'h01);
    send_frame(1);
    settle();

    // Raw 1x1 with width 0: last byte also completes the pixel
    set_frame(1'b0, 11'd0, 11'd1);
    put_word(16'hFFFF);
    send_frame(1);
    // Raw odd byte count
    put_word(16'h0000);
    frame_bytes.push_back(8'hA5);
    send_frame(1);
    settle();
    // Raw too few words, then surplus words
    write_reg(CFG_IDX_HEIGHT, 11'd2);
    put_word(16'h1234);
    send_frame(1);
    repeat (3) put_word(16'($urandom_range(0, 65535)));
    send_frame(1);
    settle();

    // Width above the largest side: full-width run, then a run ending at the last column
    set_frame(1'b1, 11'd2047, 11'd1);
    put_word(16'd1);
    put_word(16'd1024);
    put_word(16'hFFFF);
    send_frame(1);
    put_word(16'd2);
    put_word(16'd1023);
    put_word(16'h0000);
    put_word(16'd1);
    put_word(16'h5555);
    send_frame(1);
    settle();

    // Run-length defects on a 2x1 picture with height 0
    write_reg(CFG_IDX_WIDTH, 11'd2);
    write_reg(CFG_IDX_HEIGHT, 11'd0);
    put_word(16'd0);
    put_word(16'd1);
    send_frame(1);
    put_word(16'd1);
    put_word(16'd0);
    put_word(16'hAAAA);
    send_frame(1);
    put_word(16'd1);
    put_word(16'd3);
    put_word(16'h07E0);
    send_frame(1);
    put_word(16'd1);
    put_word(16'd1);
    put_word(16'h001F);
    send_frame(1);
    put_word(16'd1);
    put_word(16'd2);
    put_word(16'h8000);
    frame_bytes.push_back(8'h7F);
    send_frame(1);
    settle();

    // Shrink the height in the middle of a raw frame
    set_frame(1'b0, 11'd4, 11'd4);
    repeat (3) put_word(16'($urandom_range(0, 65535)));
    send_frame(0);
    settle();
    write_reg(CFG_IDX_HEIGHT, 11'd1);
    repeat (2) put_word(16'($urandom_range(0, 65535)));
    send_frame(1);
    settle();

    // Tall raw picture, one column, cut short
    set_frame(1'b0, 11'd1, 11'd2047);
    repeat (20) put_word(16'($urandom_range(0, 65535)));
    send_frame(1);
    settle();

    // Random settings, each followed by a few frames
    while (rand_bytes < RAND_BYTES) begin
      mode = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
        0:       w_set = 11'd0;
        1:       w_set = $urandom_range(0, 1) ? 11'd1024 : 11'd2047;
        2:       w_set = CFG_W'($urandom_range(9, 1023));
        default: w_set = CFG_W'($urandom_range(1, 8));
      endcase
      w_eff = clamp_side(w_set);
      if ($urandom_range(0, 9) == 0) h_set = 11'd0;
      else if (w_eff > 8) h_set = CFG_W'($urandom_range(1, 2));
      else h_set = CFG_W'($urandom_range(1, 4));
      h_eff = clamp_side(h_set);
      set_frame(mode, w_set, h_set);
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 9))
          6, 7, 8: flaw = flaw_t'($urandom_range(FL_ZERO_COUNT, FL_TRAILING));
          9:       flaw = FL_NONE;
          default: flaw = FL_NONE;
        endcase
        if ($urandom_range(0, 9) == 9) begin
          // Noise: random bytes closed by a last byte
          repeat ($urandom_range(1, 10)) frame_bytes.push_back(8'($urandom_range(0, 255)));
        end else if (mode) begin
          build_rle(w_eff, h_eff, flaw);
        end else begin
          build_raw(w_eff, h_eff, flaw);
        end
        rand_bytes += frame_bytes.size();
        send_frame(1);
        if (rand_bytes > RAND_BYTES * 3 / 4) calm = 1'b1;
        if ($urandom_range(0, 3) == 0) settle();
      end
      settle();
    end

    settle();
    repeat (2 * DRAIN_WAIT) @(posedge clk);
    if (runs_due.size() != 0) begin
      $display("%0d expected results never arrived", runs_due.size());
      fails += runs_due.size();
    end
    $display("fed %0d bytes; checked %0d runs and %0d frame ends in raw and run-length modes",
             bytes_fed, runs_checked, frames_checked);
    if (fails == 0) begin
      $display("rle_rgb565_frame_decoder_test: clean");
    end else begin
      $display("%0d mismatches", fails);
      $display("rle_rgb565_frame_decoder_test: errors");
    end
    $finish;
  end

endmodule
